// ===== rtl/core/u2d_pkg.sv =====
// shared types and constants for the binary to decimal text converter
`timescale 1ns / 1ps

package u2d_pkg;

  localparam int unsigned DIGIT_W = 4;
  localparam logic [5:0] ASCII_ZERO = 6'd48;
  localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADJUST = 4'd3;

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_CONVERT = 4'b0010,
    ST_SKIP    = 4'b0100,
    ST_EMIT    = 4'b1000
  } state_t;

  // commands from the sequencer to the digit unit
  typedef struct packed {
    logic clear;        // zero all digits
    logic dabble;       // add-3 correct and shift in one binary bit
    logic dabble_bit;   // bit shifted in on dabble
    logic digit_shift;  // move every digit up one place
  } dabble_ctrl_t;

endpackage

// ===== rtl/core/u2d_dabble_unit.sv =====
// bcd digit register with the shared shift-and-add-3 step
`timescale 1ns / 1ps

module u2d_dabble_unit
  import u2d_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 20
) (
  input  logic                clk,
  input  dabble_ctrl_t        ctrl,
  output logic [DIGIT_W-1:0]  top_digit,
  output logic                carry_out
);

  localparam int unsigned BCD_W = MAX_DIGITS * DIGIT_W;

  logic [BCD_W-1:0] bcd;
  logic [BCD_W-1:0] corrected;

  // per-digit correction, digits are independent
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= DABBLE_LIMIT) begin
        corrected[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + DABBLE_ADJUST;
      end else begin
        corrected[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  assign carry_out = corrected[BCD_W-1];
  assign top_digit = bcd[BCD_W-1 -: DIGIT_W];

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      bcd <= '0;
    end else if (ctrl.dabble) begin
      bcd <= {corrected[BCD_W-2:0], ctrl.dabble_bit};
    end else if (ctrl.digit_shift) begin
      bcd <= {bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
  end

endmodule

// ===== rtl/core/uint64_to_decimal_text.sv =====
// top level: unsigned binary to ascii decimal text converter
//
//  channel | signals                          | transaction
//  --------+----------------------------------+-------------------------------------
//  in      | in_valid, in_ready, binary_value | one binary value to convert
//  out     | out_valid, out_ready, digit_char,| one ascii digit, most significant
//          | last_digit                       | first, last_digit on the final one
//
// one value is accepted, then shifted in msb first over VALUE_BITS shift-and-add-3
// steps through the shared digit unit, its leading zeros are suppressed, and its
// digits are then delivered, one on each accepted out handshake
// in_ready is high only while the sequencer is idle
// a stalled out_ready simply holds the current digit on the port
// rst is synchronous and returns the sequencer to idle
`timescale 1ns / 1ps

module uint64_to_decimal_text
  import u2d_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 64,
  parameter int unsigned MAX_DIGITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] binary_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  digit_char,
  output logic        last_digit
);

  localparam int unsigned BCW = $clog2(VALUE_BITS + 1);
  localparam int unsigned DCW = $clog2(MAX_DIGITS + 1);

  state_t                 state;
  state_t                 state_next;
  logic [VALUE_BITS-1:0]  value;     // binary bits still to shift in, msb first
  logic [BCW-1:0]         bit_cnt;
  logic [DCW-1:0]         digit_cnt; // digits left in the window
  logic                   overflow;  // value needs more than MAX_DIGITS digits
  dabble_ctrl_t           ctrl;
  logic [DIGIT_W-1:0]     top_digit;
  logic                   carry_out;

  logic in_fire;
  logic out_fire;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_EMIT);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  assign digit_char = ASCII_ZERO + {2'b00, top_digit};
  assign last_digit = (digit_cnt == DCW'(1));

  // unit commands
  always_comb begin
    ctrl.clear       = in_fire;
    ctrl.dabble      = (state == ST_CONVERT);
    ctrl.dabble_bit  = value[VALUE_BITS-1];
    ctrl.digit_shift = 1'b0;
    case (state)
      ST_SKIP: begin
        // drop a leading zero unless it is the only digit left or the window overflowed
        ctrl.digit_shift = !overflow && (top_digit == '0) && (digit_cnt != DCW'(1));
      end
      ST_EMIT: begin
        ctrl.digit_shift = out_fire && (digit_cnt != DCW'(1));
      end
      default: begin
        ctrl.digit_shift = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        if (bit_cnt == BCW'(1)) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (!ctrl.digit_shift) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_fire && (digit_cnt == DCW'(1))) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath and counters
  always_ff @(posedge clk) begin
    if (in_fire) begin
      value     <= binary_value[VALUE_BITS-1:0];
      bit_cnt   <= BCW'(VALUE_BITS);
      digit_cnt <= DCW'(MAX_DIGITS);
      overflow  <= 1'b0;
    end else if (state == ST_CONVERT) begin
      value   <= {value[VALUE_BITS-2:0], 1'b0};
      bit_cnt <= bit_cnt - BCW'(1);
      // a carry out of the top digit means the full value no longer fits
      if (carry_out) begin
        overflow <= 1'b1;
      end
    end else if (ctrl.digit_shift) begin
      digit_cnt <= digit_cnt - DCW'(1);
    end
  end

  u2d_dabble_unit #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_dabble (
    .clk       (clk),
    .ctrl      (ctrl),
    .top_digit (top_digit),
    .carry_out (carry_out)
  );

endmodule

// ===== dv/u2d_text_checker.sv =====
// checker for the binary to decimal text converter: digit predictor and result compare
`timescale 1ns / 1ps

module u2d_text_checker
  import u2d_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 64,
  parameter int unsigned MAX_DIGITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [63:0] binary_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [5:0]  digit_char,
  input  logic        last_digit,
  output int          fail_count,
  output int          pending
);

  localparam int DIGIT_SLOTS = 20;
  localparam int DIGIT_LIMIT = (MAX_DIGITS < DIGIT_SLOTS) ? MAX_DIGITS : DIGIT_SLOTS;
  localparam logic [63:0] RADIX = 64'd10;

  typedef struct packed {
    logic [5:0] ch;
    logic       last;
  } digit_t;

  digit_t expected_digits[$];

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  // decimal digits of the masked value, most significant first, last one marked
  task automatic queue_decimal_digits(input logic [63:0] raw);
    logic [63:0] mask;
    logic [63:0] v;
    logic [5:0]  lsd_first[DIGIT_SLOTS];
    int          n;
    digit_t      d;
    mask = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
    v = raw & mask;
    n = 0;
    if (v == 64'd0) begin
      lsd_first[0] = 6'd0;
      n = 1;
    end else begin
      // higher digits beyond the digit register are dropped
      while (v != 64'd0 && n < DIGIT_LIMIT) begin
        lsd_first[n] = 6'(v % RADIX);
        v = v / RADIX;
        n++;
      end
    end
    for (int k = 0; k < n; k++) begin
      d.ch   = ASCII_ZERO + lsd_first[n-1-k];
      d.last = (k == n - 1);
      expected_digits = {expected_digits, d};
    end
  endtask

  always @(posedge clk) begin
    digit_t exp_d;
    if (rst) begin
      fail_count = 0;
    end else begin
      // results first: a digit leaving can never belong to a value entering now
      if (out_valid && out_ready) begin
        if (expected_digits.size() == 0) begin
          report_mismatch($sformatf("unexpected digit char=%0d last=%0b",
                                    digit_char, last_digit));
        end else begin
          exp_d = expected_digits.pop_front();
          if (digit_char !== exp_d.ch)
            report_mismatch($sformatf("digit_char got %0d want %0d", digit_char, exp_d.ch));
          if (last_digit !== exp_d.last)
            report_mismatch($sformatf("last_digit got %0b want %0b (char %0d)",
                                      last_digit, exp_d.last, exp_d.ch));
        end
      end
      if (in_valid && in_ready)
        queue_decimal_digits(binary_value);
    end
    pending = expected_digits.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// testbench top for the binary to decimal text converter: stimulus, stalls and verdict
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned VALUE_BITS = 64;
  localparam int unsigned MAX_DIGITS = 20;
  localparam int          RANDOM_ITEMS = 330;
  localparam int          CALM_ITEMS = 50;     // tail of the run with no idling
  localparam int          DRAIN_CYCLES = 150;  // covers convert, zero skip and emit
  localparam int          WATCHDOG_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] binary_value;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  digit_char;
  logic        last_digit;

  int fail_count;
  int pending;
  int stall_left = 0;
  int quiet_cycles = 0;
  bit idle_on = 1'b1;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  uint64_to_decimal_text #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .binary_value (binary_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .digit_char   (digit_char),
    .last_digit   (last_digit)
  );

  u2d_text_checker #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .binary_value (binary_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .digit_char   (digit_char),
    .last_digit   (last_digit),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // receiver back-pressure: random bursts of stalled cycles, none in the calm tail
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog: too long without any transaction on either channel ends the run
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("uint64_to_decimal_text test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a falling edge; returns at the falling edge after the transaction
  // valid stays high into the next call unless that call opens a gap first
  task automatic send_value(input logic [63:0] v);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    binary_value <= v;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  initial begin
    logic [63:0] v;
    logic [63:0] p;
    int          e;
    int          sh;

    rst          = 1'b1;
    in_valid     = 1'b0;
    binary_value = 64'd0;

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // directed: zero, single digits, digit count boundaries, 20-digit extremes
    send_value(64'd0);
    send_value(64'd1);
    send_value(64'd9);
    send_value(64'd10);
    send_value(64'd99);
    send_value(64'd100);
    send_value(64'd101);
    send_value(64'd1000000000000000001);   // inner zeros between two ones
    send_value(64'd9999999999999999999);   // widest 19-digit value
    send_value(64'd10000000000000000000);  // smallest 20-digit value
    send_value(64'hFFFF_FFFF_FFFF_FFFF);   // largest value, 20 digits
    send_value(64'h8000_0000_0000_0000);
    send_value(64'h7FFF_FFFF_FFFF_FFFF);
    send_value(64'h5555_5555_5555_5555);
    send_value(64'hAAAA_AAAA_AAAA_AAAA);
    send_value(64'h0000_0000_FFFF_FFFF);
    send_value(64'hFFFF_FFFF_0000_0000);
    send_value(64'd1234567890123456789);
    send_value(64'd0);                     // zero right after a long run
    send_value(64'd5);

    // random: spread over every digit count, with powers of ten and their neighbors
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - CALM_ITEMS)
        idle_on = 1'b0;
      case ($urandom_range(0, 5))
        0: v = {$urandom, $urandom};
        1: begin
          sh = $urandom_range(0, 63);
          v = {$urandom, $urandom} >> sh;
        end
        2: begin
          e = $urandom_range(0, 19);
          p = 64'd1;
          repeat (e) p = p * 64'd10;
          v = p + 64'($urandom_range(0, 2)) - 64'd1;
        end
        3: v = 64'($urandom_range(0, 999));
        4: v = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 255));
        default: v = {$urandom, $urandom} | 64'h8000_0000_0000_0000;
      endcase
      send_value(v);
    end
    in_valid <= 1'b0;

    // drain every outstanding digit, then let the block settle
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("uint64_to_decimal_text test passed");
    end else begin
      $display("uint64_to_decimal_text test failed");
    end
    $finish;
  end

endmodule
